// File: hdl/advm_pkg.sv
// ----------------------------------------------------------------------------
// advm_pkg: shared types and codes of the ASCII decimal VM executor
// Request and result structs, command letters, result kinds, error codes,
// sequencer states and small digit helpers.
// ----------------------------------------------------------------------------
package advm_pkg;

	localparam int PHYS_BLOCKS_DEF = 16;
	localparam int WORDS_PER_BLOCK = 10;
	localparam int LOGICAL_BLOCKS  = 10;
	localparam int PC_LAST         = LOGICAL_BLOCKS * WORDS_PER_BLOCK - 1;
	localparam int BIN_W           = 14;
	localparam int DEC_MAX         = 9999;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  word_addr;
		logic [31:0] word_data;
		logic [3:0]  page_slot;
		logic [4:0]  page_target;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] data_word;
		logic [6:0]  prog_counter;
		logic        cond_flag;
		logic [2:0]  error_code;
		logic [3:0]  request_block;
		logic        last;
	} rsp_t;

	// host opcodes
	localparam logic [1:0] OP_STEP  = 2'd0;
	localparam logic [1:0] OP_WMEM  = 2'd1;
	localparam logic [1:0] OP_WPAGE = 2'd2;
	localparam logic [1:0] OP_RMEM  = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_ACK   = 3'd0;
	localparam logic [2:0] KIND_EXEC  = 3'd1;
	localparam logic [2:0] KIND_HALT  = 3'd2;
	localparam logic [2:0] KIND_PRINT = 3'd3;
	localparam logic [2:0] KIND_INREQ = 3'd4;
	localparam logic [2:0] KIND_ERROR = 3'd5;
	localparam logic [2:0] KIND_READ  = 3'd6;

	// error codes
	localparam logic [2:0] ERR_UNKNOWN  = 3'd0;
	localparam logic [2:0] ERR_SUM      = 3'd1;
	localparam logic [2:0] ERR_NEG      = 3'd2;
	localparam logic [2:0] ERR_PRODUCT  = 3'd3;
	localparam logic [2:0] ERR_NONDIGIT = 3'd4;

	// command letter pairs
	localparam logic [15:0] CMD_KR = 16'h4B52;
	localparam logic [15:0] CMD_SR = 16'h5352;
	localparam logic [15:0] CMD_SU = 16'h5355;
	localparam logic [15:0] CMD_AT = 16'h4154;
	localparam logic [15:0] CMD_SA = 16'h5341;
	localparam logic [15:0] CMD_PR = 16'h5052;
	localparam logic [15:0] CMD_GO = 16'h474F;
	localparam logic [15:0] CMD_PT = 16'h5054;
	localparam logic [15:0] CMD_PD = 16'h5044;
	localparam logic [15:0] CMD_RD = 16'h5244;
	localparam logic [15:0] CMD_HA = 16'h4841;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HOST_RD,
		ST_FETCH,
		ST_DECODE,
		ST_OPER,
		ST_ARITH,
		ST_CONV,
		ST_PD_RD,
		ST_PD_WAIT,
		ST_EMIT
	} state_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic word_digits(input logic [31:0] w);
		return is_digit(w[31:24]) && is_digit(w[23:16]) && is_digit(w[15:8])
			&& is_digit(w[7:0]);
	endfunction

	// four ASCII digits to binary; bytes already checked
	function automatic logic [BIN_W-1:0] dec4(input logic [31:0] w);
		logic [BIN_W-1:0] v;
		v = BIN_W'(w[27:24]) * BIN_W'(1000) + BIN_W'(w[19:16]) * BIN_W'(100)
			+ BIN_W'(w[11:8]) * BIN_W'(10) + BIN_W'(w[3:0]);
		return v;
	endfunction

endpackage

// File: hdl/advm_bcd.sv
// ----------------------------------------------------------------------------
// advm_bcd: iterative binary to BCD converter
// Shift-and-add-three over one bit per cycle; busy until all BIN_W bits are shifted in.
// ----------------------------------------------------------------------------
module advm_bcd (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [advm_pkg::BIN_W-1:0]    bin,
	output logic                          busy,
	output logic [15:0]                   bcd
);

	localparam int CW = $clog2(advm_pkg::BIN_W + 1);

	logic [advm_pkg::BIN_W-1:0] sh_q;
	logic [15:0]                bcd_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic [15:0]                adj;

	// add three to every digit of five or more
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
	end

	// control: count the shifts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(advm_pkg::BIN_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// data: shift one bit into the digits
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[14:0], sh_q[advm_pkg::BIN_W-1]};
			sh_q  <= {sh_q[advm_pkg::BIN_W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign bcd  = bcd_q;

endmodule

// File: hdl/ascii_decimal_vm_executor.sv
// ----------------------------------------------------------------------------
// ascii_decimal_vm_executor: paged VM with four-digit ASCII words
// Host loads memory and page table, then steps the program one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid/req_stall/req_data) takes host commands:
//   step, write memory word, write page entry, read memory word. The result
//   channel (rsp_valid/rsp_stall/rsp_data) returns one result per request,
//   or ten print words for PD, the final one flagged by last.
//   Requests are taken one at a time: req_stall is high from acceptance until
//   the last result has been loaded into the output register.
//   Host writes go from acceptance straight to the result; reads add a memory
//   read. A step runs accept, fetch read, decode with operand read, execute,
//   result; HA, an unknown command or a non-digit operand address ends after
//   decode. SU, AT and SA add an arithmetic step and, unless the result is out
//   of range, the binary to digit conversion in the shared shift-add-three
//   unit. PD reads, waits for and emits each printed word after execute.
//   Memory is one port each for read and write with registered read data.
//   Reset clears PC, R and C; memory and page table hold nothing defined
//   until written. A stalled receiver holds the result register and the
//   sequencer waits in its result state; nothing is dropped.
// ----------------------------------------------------------------------------
module ascii_decimal_vm_executor #(
	parameter int PHYS_BLOCKS = advm_pkg::PHYS_BLOCKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  advm_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output advm_pkg::rsp_t  rsp_data
);

	localparam int DEPTH = PHYS_BLOCKS * advm_pkg::WORDS_PER_BLOCK;
	localparam int IW    = $clog2(DEPTH);

	advm_pkg::state_t state_q, state_nx;

	logic [31:0] mem [DEPTH];
	logic [31:0] mem_q;
	logic        rd_ok_q;
	logic [4:0]  pt_q [advm_pkg::LOGICAL_BLOCKS];

	logic [6:0]  pc_q;
	logic [31:0] acc_q;
	logic        cflag_q;
	logic [31:0] ins_q;
	logic [advm_pkg::BIN_W-1:0] a_q, b_q;
	logic [3:0]  k_q;
	logic [2:0]  res_kind_q;
	logic [31:0] res_data_q;
	logic [2:0]  res_err_q;
	logic [3:0]  res_req_q;
	logic        res_last_q;
	logic        pd_more_q;

	logic        rsp_valid_q;
	advm_pkg::rsp_t rsp_q;

	logic        accept, out_free;
	logic [3:0]  map_blk, map_fld;
	logic [4:0]  pt_e;
	logic        map_ok;
	logic [8:0]  map_idx;
	logic        rd_en, rd_ok, wr_en;
	logic [IW-1:0] rd_idx, wr_idx;
	logic [31:0] wr_data;
	logic [31:0] rd_word;
	logic [14:0] pc_mul;
	logic [3:0]  pc_blk, pc_fld;
	logic [15:0] cmd_dec, cmd_op;
	logic        known, dig_ok, arith;
	logic [3:0]  op_blk, op_fld;
	logic [advm_pkg::BIN_W:0] sum_w;
	logic [27:0] prod_w;
	logic        bcd_start, bcd_busy;
	logic [15:0] bcd;

	assign req_stall = (state_q != advm_pkg::ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rd_word   = rd_ok_q ? mem_q : 32'd0;

	// split PC into block and field
	assign pc_mul = 15'(pc_q) * 15'd205;
	assign pc_blk = pc_mul[14:11];
	assign pc_fld = 4'(pc_q - 7'(pc_blk) * 7'd10);

	// decode of the fetched word and of the held instruction
	assign cmd_dec = rd_word[31:16];
	assign known = (cmd_dec == advm_pkg::CMD_KR) || (cmd_dec == advm_pkg::CMD_SR)
		|| (cmd_dec == advm_pkg::CMD_SU) || (cmd_dec == advm_pkg::CMD_AT)
		|| (cmd_dec == advm_pkg::CMD_SA) || (cmd_dec == advm_pkg::CMD_PR)
		|| (cmd_dec == advm_pkg::CMD_GO) || (cmd_dec == advm_pkg::CMD_PT)
		|| (cmd_dec == advm_pkg::CMD_PD) || (cmd_dec == advm_pkg::CMD_RD);
	assign dig_ok = advm_pkg::is_digit(rd_word[15:8]) && advm_pkg::is_digit(rd_word[7:0]);
	assign cmd_op = ins_q[31:16];
	assign op_blk = ins_q[11:8];
	assign op_fld = ins_q[3:0];
	assign arith  = (cmd_op == advm_pkg::CMD_SU) || (cmd_op == advm_pkg::CMD_AT)
		|| (cmd_op == advm_pkg::CMD_SA);

	// page mapping of one logical word
	assign pt_e    = (map_blk < 4'(advm_pkg::LOGICAL_BLOCKS)) ? pt_q[map_blk] : 5'd0;
	assign map_ok  = (map_blk < 4'(advm_pkg::LOGICAL_BLOCKS))
		&& (map_fld < 4'(advm_pkg::WORDS_PER_BLOCK))
		&& (pt_e != 5'd0) && (int'(pt_e) <= PHYS_BLOCKS);
	assign map_idx = 9'(pt_e - 5'd1) * 9'd10 + 9'(map_fld);

	// arithmetic on the decoded operands
	assign sum_w  = (advm_pkg::BIN_W+1)'(a_q) + (advm_pkg::BIN_W+1)'(b_q);
	assign prod_w = 28'(a_q) * 28'(b_q);

	assign bcd_start = (state_q == advm_pkg::ST_ARITH) && !(
		((cmd_op == advm_pkg::CMD_SU) && (int'(sum_w) > advm_pkg::DEC_MAX))
		|| ((cmd_op == advm_pkg::CMD_AT) && (a_q < b_q))
		|| ((cmd_op == advm_pkg::CMD_SA) && (int'(prod_w) > advm_pkg::DEC_MAX)));

	advm_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.bin    ((cmd_op == advm_pkg::CMD_SU) ? advm_pkg::BIN_W'(sum_w)
			: (cmd_op == advm_pkg::CMD_AT) ? a_q - b_q : advm_pkg::BIN_W'(prod_w)),
		.busy   (bcd_busy),
		.bcd    (bcd)
	);

	// select memory addresses for this cycle
	always_comb begin
		map_blk = op_blk;
		map_fld = op_fld;
		rd_en   = 1'b0;
		rd_ok   = 1'b0;
		rd_idx  = IW'(map_idx);
		wr_en   = 1'b0;
		wr_idx  = IW'(map_idx);
		wr_data = acc_q;
		unique case (state_q)
			advm_pkg::ST_IDLE: begin
				rd_idx  = IW'(req_data.word_addr);
				wr_idx  = IW'(req_data.word_addr);
				wr_data = req_data.word_data;
				rd_en   = accept && (req_data.opcode == advm_pkg::OP_RMEM);
				rd_ok   = int'(req_data.word_addr) < DEPTH;
				wr_en   = accept && (req_data.opcode == advm_pkg::OP_WMEM)
					&& (int'(req_data.word_addr) < DEPTH);
			end
			advm_pkg::ST_FETCH: begin
				map_blk = pc_blk;
				map_fld = pc_fld;
				rd_en   = 1'b1;
				rd_ok   = map_ok;
			end
			advm_pkg::ST_DECODE: begin
				map_blk = rd_word[11:8];
				map_fld = rd_word[3:0];
				rd_en   = 1'b1;
				rd_ok   = map_ok;
			end
			advm_pkg::ST_OPER: begin
				wr_en = (cmd_op == advm_pkg::CMD_SR) && map_ok;
			end
			advm_pkg::ST_PD_RD: begin
				map_fld = k_q;
				rd_en   = 1'b1;
				rd_ok   = map_ok;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			advm_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req_data.opcode)
						advm_pkg::OP_STEP: state_nx = advm_pkg::ST_FETCH;
						advm_pkg::OP_RMEM: state_nx = advm_pkg::ST_HOST_RD;
						default:           state_nx = advm_pkg::ST_EMIT;
					endcase
				end
			end
			advm_pkg::ST_HOST_RD: state_nx = advm_pkg::ST_EMIT;
			advm_pkg::ST_FETCH:   state_nx = advm_pkg::ST_DECODE;
			advm_pkg::ST_DECODE: begin
				if ((cmd_dec == advm_pkg::CMD_HA) || !known || !dig_ok) begin
					state_nx = advm_pkg::ST_EMIT;
				end else begin
					state_nx = advm_pkg::ST_OPER;
				end
			end
			advm_pkg::ST_OPER: begin
				if (cmd_op == advm_pkg::CMD_PD) begin
					state_nx = advm_pkg::ST_PD_RD;
				end else if (arith && advm_pkg::word_digits(rd_word)
					&& advm_pkg::word_digits(acc_q)) begin
					state_nx = advm_pkg::ST_ARITH;
				end else begin
					state_nx = advm_pkg::ST_EMIT;
				end
			end
			advm_pkg::ST_ARITH: state_nx = bcd_start ? advm_pkg::ST_CONV : advm_pkg::ST_EMIT;
			advm_pkg::ST_CONV:  state_nx = bcd_busy ? advm_pkg::ST_CONV : advm_pkg::ST_EMIT;
			advm_pkg::ST_PD_RD: state_nx = advm_pkg::ST_PD_WAIT;
			advm_pkg::ST_PD_WAIT: state_nx = advm_pkg::ST_EMIT;
			advm_pkg::ST_EMIT: begin
				if (out_free) begin
					state_nx = pd_more_q ? advm_pkg::ST_PD_RD : advm_pkg::ST_IDLE;
				end
			end
			default: state_nx = advm_pkg::ST_IDLE;
		endcase
	end

	// memory: one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= mem[rd_idx];
		end
	end

	// page table writes from the host
	always_ff @(posedge clk) begin
		if (accept && (req_data.opcode == advm_pkg::OP_WPAGE)
			&& (req_data.page_slot < 4'(advm_pkg::LOGICAL_BLOCKS))) begin
			pt_q[req_data.page_slot] <= req_data.page_target;
		end
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= advm_pkg::ST_IDLE;
			pc_q      <= '0;
			acc_q     <= '0;
			cflag_q   <= 1'b0;
			rd_ok_q   <= 1'b0;
			pd_more_q <= 1'b0;
			k_q       <= '0;
		end else begin
			state_q <= state_nx;
			if (rd_en) begin
				rd_ok_q <= rd_ok;
			end
			unique case (state_q)
				advm_pkg::ST_FETCH: begin
					pc_q <= (pc_q == 7'(advm_pkg::PC_LAST)) ? 7'd0 : pc_q + 7'd1;
				end
				advm_pkg::ST_OPER: begin
					if (cmd_op == advm_pkg::CMD_KR) begin
						acc_q <= rd_word;
					end
					if (cmd_op == advm_pkg::CMD_PR) begin
						cflag_q <= (acc_q == rd_word);
					end
					if ((cmd_op == advm_pkg::CMD_GO)
						|| ((cmd_op == advm_pkg::CMD_PT) && cflag_q)) begin
						pc_q <= 7'(op_blk) * 7'd10 + 7'(op_fld);
					end
					k_q <= '0;
				end
				advm_pkg::ST_CONV: begin
					if (!bcd_busy) begin
						acc_q <= {4'h3, bcd[15:12], 4'h3, bcd[11:8],
							4'h3, bcd[7:4], 4'h3, bcd[3:0]};
					end
				end
				advm_pkg::ST_PD_WAIT: begin
					pd_more_q <= (k_q != 4'(advm_pkg::WORDS_PER_BLOCK - 1));
					k_q       <= k_q + 4'd1;
				end
				advm_pkg::ST_EMIT: begin
					if (out_free) begin
						pd_more_q <= 1'b0;
					end
				end
				default: begin
					pd_more_q <= pd_more_q;
				end
			endcase
		end
	end

	// pending result and operand registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			advm_pkg::ST_IDLE: begin
				res_kind_q <= advm_pkg::KIND_ACK;
				res_err_q  <= advm_pkg::ERR_UNKNOWN;
				res_req_q  <= '0;
				res_last_q <= 1'b1;
				res_data_q <= '0;
			end
			advm_pkg::ST_HOST_RD: begin
				res_kind_q <= advm_pkg::KIND_READ;
				res_data_q <= rd_word;
			end
			advm_pkg::ST_DECODE: begin
				ins_q <= rd_word;
				if (cmd_dec == advm_pkg::CMD_HA) begin
					res_kind_q <= advm_pkg::KIND_HALT;
				end else if (!known) begin
					res_kind_q <= advm_pkg::KIND_ERROR;
				end else if (!dig_ok) begin
					res_kind_q <= advm_pkg::KIND_ERROR;
					res_err_q  <= advm_pkg::ERR_NONDIGIT;
				end else begin
					res_kind_q <= advm_pkg::KIND_EXEC;
				end
			end
			advm_pkg::ST_OPER: begin
				a_q <= advm_pkg::dec4(rd_word);
				b_q <= advm_pkg::dec4(acc_q);
				if (cmd_op == advm_pkg::CMD_RD) begin
					res_kind_q <= advm_pkg::KIND_INREQ;
					res_req_q  <= op_blk;
				end else if (arith && !(advm_pkg::word_digits(rd_word)
					&& advm_pkg::word_digits(acc_q))) begin
					res_kind_q <= advm_pkg::KIND_ERROR;
					res_err_q  <= advm_pkg::ERR_NONDIGIT;
				end
			end
			advm_pkg::ST_ARITH: begin
				if (!bcd_start) begin
					res_kind_q <= advm_pkg::KIND_ERROR;
					case (cmd_op)
						advm_pkg::CMD_SU: res_err_q <= advm_pkg::ERR_SUM;
						advm_pkg::CMD_AT: res_err_q <= advm_pkg::ERR_NEG;
						default:          res_err_q <= advm_pkg::ERR_PRODUCT;
					endcase
				end
			end
			advm_pkg::ST_PD_WAIT: begin
				res_kind_q <= advm_pkg::KIND_PRINT;
				res_data_q <= rd_word;
				res_last_q <= (k_q == 4'(advm_pkg::WORDS_PER_BLOCK - 1));
			end
			default: begin
				res_data_q <= res_data_q;
			end
		endcase
	end

	// output register: load on a free slot, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == advm_pkg::ST_EMIT) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == advm_pkg::ST_EMIT) && out_free) begin
			rsp_q.kind          <= res_kind_q;
			rsp_q.data_word     <= ((res_kind_q == advm_pkg::KIND_PRINT)
				|| (res_kind_q == advm_pkg::KIND_READ)) ? res_data_q : acc_q;
			rsp_q.prog_counter  <= pc_q;
			rsp_q.cond_flag     <= cflag_q;
			rsp_q.error_code    <= res_err_q;
			rsp_q.request_block <= res_req_q;
			rsp_q.last          <= res_last_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
